### rtl/core/window_quadratic_jet_fit_2d_macros.svh
// Assertion macros used by the port checker of the jet fit block.
`ifndef WINDOW_QUADRATIC_JET_FIT_2D_MACROS_SVH
`define WINDOW_QUADRATIC_JET_FIT_2D_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define WQJF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define WQJF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/wqjf_pkg.sv
// Types, constants and helper functions shared by the jet fit block.
package wqjf_pkg;

   localparam int ROW_BITS       = 32;
   localparam int WIN_BITS       = 54;
   localparam int JET_BITS       = 32;
   localparam int SCALE_BITS     = 24;
   localparam int SIZE_BITS      = 5;
   localparam int INDEX_BITS     = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int NUM_JETS       = 6;
   localparam int JET_INDEX_BITS = 3;
   localparam int SAT_IN_BITS    = 50;

   localparam logic [SIZE_BITS-1:0] WINDOW_SIZE_RESET = 5'd3;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_SIZE      = 3'd0,
      CSR_SCALE_CONST      = 3'd1,
      CSR_SCALE_LINEAR     = 3'd2,
      CSR_SCALE_CROSS      = 3'd3,
      CSR_SCALE_SQUARE     = 3'd4,
      CSR_CONST_CORRECTION = 3'd5
   } csr_index_type;

   // Positions of the window sums and of the jet coefficients.
   localparam logic [JET_INDEX_BITS-1:0] J_CONST = 3'd0;
   localparam logic [JET_INDEX_BITS-1:0] J_DX    = 3'd1;
   localparam logic [JET_INDEX_BITS-1:0] J_DY    = 3'd2;
   localparam logic [JET_INDEX_BITS-1:0] J_DXX   = 3'd3;
   localparam logic [JET_INDEX_BITS-1:0] J_DXY   = 3'd4;
   localparam logic [JET_INDEX_BITS-1:0] J_DYY   = 3'd5;

   typedef logic [NUM_JETS-1:0][WIN_BITS-1:0] win_sums_type;
   typedef logic [NUM_JETS-1:0][JET_BITS-1:0] jets_type;

   typedef struct packed {
      logic signed [SCALE_BITS-1:0] scale_const;
      logic signed [SCALE_BITS-1:0] scale_linear;
      logic signed [SCALE_BITS-1:0] scale_cross;
      logic signed [SCALE_BITS-1:0] scale_square;
      logic signed [SCALE_BITS-1:0] const_correction;
   } scale_cfg_type;

   // Clamp a signed value to the 32-bit jet range.
   function automatic logic [JET_BITS-1:0] sat_jet(input logic signed [SAT_IN_BITS-1:0] v);
      logic [SAT_IN_BITS-JET_BITS:0] top_bits;
      top_bits = v[SAT_IN_BITS-1:JET_BITS-1];
      if (top_bits == '0 || top_bits == '1) begin
         return v[JET_BITS-1:0];
      end else if (v[SAT_IN_BITS-1]) begin
         return {1'b1, {(JET_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(JET_BITS-1){1'b1}}};
      end
   endfunction

endpackage

### rtl/core/wqjf_ram.sv
// Generic RAM with one write port and two registered read ports.
module wqjf_ram #(
   parameter int WIDTH = 54,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   output logic [WIDTH-1:0]     rd_data_a,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [WIDTH-1:0]     rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Reads return the contents from before a write in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### rtl/core/wqjf_scale.sv
// Sequential scaling unit: scales the six window sums and corrects the constant.
module wqjf_scale import wqjf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  win_sums_type  win_sums,
   input  scale_cfg_type cfg,
   output logic          busy,
   output jets_type      jets
);

   localparam int LO_BITS    = 30;
   localparam int MUL_A_BITS = JET_BITS + 1;
   localparam int MUL_P_BITS = MUL_A_BITS + SCALE_BITS;
   localparam int PART_BITS  = MUL_P_BITS - LO_BITS;
   localparam int ACC_BITS   = 49;
   localparam int CORR_SHIFT = 16;
   localparam int CORR_BITS  = MUL_P_BITS - CORR_SHIFT;

   localparam logic signed [MUL_P_BITS-1:0] LO_HALF   = MUL_P_BITS'(1) << (LO_BITS - 1);
   localparam logic signed [MUL_P_BITS-1:0] CORR_HALF = MUL_P_BITS'(1) << (CORR_SHIFT - 1);

   typedef enum logic [5:0] {
      F_IDLE = 6'b000001,
      F_LO   = 6'b000010,
      F_HI   = 6'b000100,
      F_SUM  = 6'b001000,
      F_CORR = 6'b010000,
      F_OUT  = 6'b100000
   } scale_state_type;

   scale_state_type                state_ff, state_in;
   logic [JET_INDEX_BITS-1:0]      k_ff, k_in;
   logic signed [PART_BITS-1:0]    part_ff;
   logic signed [ACC_BITS-1:0]     const_ff;
   logic signed [MUL_A_BITS-1:0]   sum_ff;
   logic signed [CORR_BITS-1:0]    corr_ff;
   jets_type                       jets_ff;

   logic [WIN_BITS-1:0]            w_sel;
   logic signed [SCALE_BITS-1:0]   s_sel;
   logic signed [MUL_A_BITS-1:0]   mul_a;
   logic signed [SCALE_BITS-1:0]   mul_b;
   logic signed [MUL_P_BITS-1:0]   prod;
   logic signed [MUL_P_BITS-1:0]   lo_rnd;
   logic signed [MUL_P_BITS-1:0]   corr_rnd;
   logic signed [ACC_BITS-1:0]     acc;
   logic signed [MUL_A_BITS-1:0]   sq_sum;
   logic signed [SAT_IN_BITS-1:0]  const_fix;

   assign w_sel = win_sums[k_ff];

   always_comb begin
      case (k_ff)
         J_CONST:      s_sel = cfg.scale_const;
         J_DX, J_DY:   s_sel = cfg.scale_linear;
         J_DXX, J_DYY: s_sel = cfg.scale_square;
         J_DXY:        s_sel = cfg.scale_cross;
         default:      s_sel = cfg.scale_const;
      endcase
   end

   // A sum is split into an unsigned low part of 30 bits and a signed high part.
   always_comb begin
      case (state_ff)
         F_LO:    mul_a = MUL_A_BITS'($signed({1'b0, w_sel[LO_BITS-1:0]}));
         F_HI:    mul_a = MUL_A_BITS'($signed(w_sel[WIN_BITS-1:LO_BITS]));
         F_CORR:  mul_a = sum_ff;
         default: mul_a = '0;
      endcase
      mul_b = (state_ff == F_CORR) ? cfg.const_correction : s_sel;
   end

   assign prod      = mul_a * mul_b;
   assign lo_rnd    = prod + LO_HALF;
   assign corr_rnd  = prod + CORR_HALF;
   assign acc       = $signed(prod[ACC_BITS-1:0]) + ACC_BITS'(part_ff);
   assign sq_sum    = MUL_A_BITS'($signed(jets_ff[J_DXX])) + MUL_A_BITS'($signed(jets_ff[J_DYY]));
   assign const_fix = SAT_IN_BITS'(const_ff) - SAT_IN_BITS'(corr_ff);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               state_in = F_LO;
               k_in     = J_CONST;
            end
         end
         F_LO:   state_in = F_HI;
         F_HI: begin
            if (k_ff == J_DYY) begin
               state_in = F_SUM;
            end else begin
               state_in = F_LO;
               k_in     = k_ff + JET_INDEX_BITS'(1);
            end
         end
         F_SUM:  state_in = F_CORR;
         F_CORR: state_in = F_OUT;
         F_OUT:  state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         k_ff     <= J_CONST;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         F_LO: part_ff <= lo_rnd[MUL_P_BITS-1:LO_BITS];
         F_HI: begin
            if (k_ff == J_CONST) begin
               const_ff <= acc;
            end else begin
               jets_ff[k_ff] <= sat_jet(SAT_IN_BITS'(acc));
            end
         end
         F_SUM:  sum_ff <= sq_sum;
         F_CORR: corr_ff <= corr_rnd[MUL_P_BITS-1:CORR_SHIFT];
         F_OUT:  jets_ff[J_CONST] <= sat_jet(const_fix);
         default: ;
      endcase
   end

   assign busy = (state_ff != F_IDLE);
   assign jets = jets_ff;

endmodule

### rtl/core/window_quadratic_jet_fit_2d.sv
// Top level of the weighted quadratic jet fit over a square pixel window.
//
//   Channel  Direction  Handshake            Word contents
//   req      in         req_valid/req_stall  opcode, coef_index, three coefficients, pixel
//   rsp      out        rsp_valid/rsp_stall  six saturated jet coefficients
//   csr      in         csr_we               register index and write data
//
// A coefficient load and a pixel inside a row are each taken without a stall. The last
// pixel of a row stalls the request channel while the row sums are projected into the
// window sums through one shared multiplier. The last pixel of a window then starts the
// scaling unit, and the stall lasts until it is done and the output register is free.
// Reset is synchronous; the coefficient tables are not cleared.
// A finished word waits in the output register while the next window streams in.
module window_quadratic_jet_fit_2d import wqjf_pkg::*; #(
   parameter int MAX_WINDOW = 16,
   parameter int COEF_BITS  = 18,
   parameter int PIXEL_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_opcode,
   input  logic [INDEX_BITS-1:0]        req_coef_index,
   input  logic signed [COEF_BITS-1:0]  req_coef_const,
   input  logic signed [COEF_BITS-1:0]  req_coef_lin,
   input  logic signed [COEF_BITS-1:0]  req_coef_quad,
   input  logic [PIXEL_BITS-1:0]        req_pixel,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [JET_BITS-1:0]   rsp_jet_const,
   output logic signed [JET_BITS-1:0]   rsp_jet_dx,
   output logic signed [JET_BITS-1:0]   rsp_jet_dy,
   output logic signed [JET_BITS-1:0]   rsp_jet_dxx,
   output logic signed [JET_BITS-1:0]   rsp_jet_dxy,
   output logic signed [JET_BITS-1:0]   rsp_jet_dyy,
   // configuration port
   input  logic                         csr_we,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [SCALE_BITS-1:0]        csr_wdata
);

   localparam int CNT_BITS  = $clog2(MAX_WINDOW);
   localparam int N_BITS    = CNT_BITS + 1;
   localparam int TAB_W     = 3 * COEF_BITS;
   localparam int PIX_PROD  = COEF_BITS + PIXEL_BITS + 1;
   localparam int PIX_EXT   = (PIX_PROD > ROW_BITS) ? PIX_PROD : ROW_BITS;
   localparam int PROJ_PROD = COEF_BITS + ROW_BITS;
   localparam int PROJ_EXT  = (PROJ_PROD > WIN_BITS) ? PROJ_PROD : WIN_BITS;

   typedef enum logic [2:0] {
      ST_RUN  = 3'b001,
      ST_PROJ = 3'b010,
      ST_FIN  = 3'b100
   } top_state_type;

   top_state_type                state_ff, state_in;
   logic [CNT_BITS-1:0]          col_ff, col_in;
   logic [CNT_BITS-1:0]          row_ff, row_in;
   logic [2:0][ROW_BITS-1:0]     row_sums_ff, row_sums_in;
   win_sums_type                 win_ff, win_in;
   logic [JET_INDEX_BITS-1:0]    step_ff, step_in;
   logic                         win_end_ff, win_end_in;
   logic [TAB_W-1:0]             coef_row_ff;
   logic [TAB_W-1:0]             byp_a_ff, byp_b_ff;
   logic                         hit_a_ff, hit_b_ff;
   logic [SIZE_BITS-1:0]         window_size_ff;
   scale_cfg_type                cfg_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   jets_type                     rsp_jets_ff;

   logic                         req_take, is_load, is_pixel;
   logic                         wr_en;
   logic [CNT_BITS-1:0]          wr_addr;
   logic [TAB_W-1:0]             wr_data;
   logic [TAB_W-1:0]             rd_data_a, rd_data_b;
   logic [TAB_W-1:0]             tab_a, tab_b;
   logic [N_BITS-1:0]            n_eff;
   logic                         col_last, row_last;
   logic signed [PIX_PROD-1:0]   pix_prod [3];
   logic signed [PIX_EXT-1:0]    pix_ext [3];
   logic [2:0][ROW_BITS-1:0]     row_mac;
   logic signed [COEF_BITS-1:0]  proj_coef;
   logic signed [ROW_BITS-1:0]   proj_sum;
   logic signed [PROJ_PROD-1:0]  proj_prod;
   logic signed [PROJ_EXT-1:0]   proj_ext;
   logic                         fin_start, fin_busy;
   jets_type                     fin_jets;
   logic                         rsp_load;

   // ---------------------------------------------------------------------------
   // Handshake. Items are taken only while the row and window pipeline is idle.
   // ---------------------------------------------------------------------------
   assign req_stall = (state_ff != ST_RUN);
   assign req_take  = req_valid && !req_stall;
   assign is_load   = req_take && (req_opcode == OP_LOAD);
   assign is_pixel  = req_take && (req_opcode == OP_PIXEL);

   // ---------------------------------------------------------------------------
   // Coefficient tables. One memory holds all three tables side by side. Port A
   // is always addressed with the next column and port B with the next row, so
   // the entry a pixel needs is already on the read data when the pixel arrives.
   // A load into the entry being read is forwarded through a bypass register.
   // ---------------------------------------------------------------------------
   assign wr_en   = is_load && (32'(req_coef_index) < MAX_WINDOW);
   assign wr_addr = CNT_BITS'(req_coef_index);
   assign wr_data = {req_coef_quad, req_coef_lin, req_coef_const};

   wqjf_ram #(
      .WIDTH (TAB_W),
      .DEPTH (MAX_WINDOW)
   ) u_tables (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (col_in),
      .rd_data_a (rd_data_a),
      .rd_addr_b (row_in),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else begin
         hit_a_ff <= wr_en && (wr_addr == col_in);
         hit_b_ff <= wr_en && (wr_addr == row_in);
      end
      if (wr_en) begin
         byp_a_ff <= wr_data;
         byp_b_ff <= wr_data;
      end
   end

   assign tab_a = hit_a_ff ? byp_a_ff : rd_data_a;
   assign tab_b = hit_b_ff ? byp_b_ff : rd_data_b;

   // The configured side is clamped into the range the counters support.
   always_comb begin
      if (window_size_ff < SIZE_BITS'(2)) begin
         n_eff = N_BITS'(2);
      end else if (32'(window_size_ff) > MAX_WINDOW) begin
         n_eff = N_BITS'(MAX_WINDOW);
      end else begin
         n_eff = N_BITS'(window_size_ff);
      end
   end

   // A row or window ends once its counter reaches or passes the last position,
   // which also covers a size that shrank in the middle of a window.
   assign col_last = ({1'b0, col_ff} + N_BITS'(1)) >= n_eff;
   assign row_last = ({1'b0, row_ff} + N_BITS'(1)) >= n_eff;

   // Three row accumulators, one per basis, each wrapping at 32 bits.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pix_prod[i] = $signed(tab_a[i*COEF_BITS +: COEF_BITS]) * $signed({1'b0, req_pixel});
         pix_ext[i]  = PIX_EXT'(pix_prod[i]);
         row_mac[i]  = row_sums_ff[i] + pix_ext[i][ROW_BITS-1:0];
      end
   end

   // Row projection: one product per step, in the order of the window sums.
   always_comb begin
      case (step_ff)
         J_CONST: begin
            proj_coef = $signed(coef_row_ff[COEF_BITS-1:0]);
            proj_sum  = $signed(row_sums_ff[0]);
         end
         J_DX: begin
            proj_coef = $signed(coef_row_ff[COEF_BITS-1:0]);
            proj_sum  = $signed(row_sums_ff[1]);
         end
         J_DY: begin
            proj_coef = $signed(coef_row_ff[2*COEF_BITS-1:COEF_BITS]);
            proj_sum  = $signed(row_sums_ff[0]);
         end
         J_DXX: begin
            proj_coef = $signed(coef_row_ff[COEF_BITS-1:0]);
            proj_sum  = $signed(row_sums_ff[2]);
         end
         J_DXY: begin
            proj_coef = $signed(coef_row_ff[2*COEF_BITS-1:COEF_BITS]);
            proj_sum  = $signed(row_sums_ff[1]);
         end
         J_DYY: begin
            proj_coef = $signed(coef_row_ff[3*COEF_BITS-1:2*COEF_BITS]);
            proj_sum  = $signed(row_sums_ff[0]);
         end
         default: begin
            proj_coef = '0;
            proj_sum  = '0;
         end
      endcase
   end

   assign proj_prod = proj_coef * proj_sum;
   assign proj_ext  = PROJ_EXT'(proj_prod);

   assign rsp_load = (state_ff == ST_FIN) && !fin_busy && (!rsp_valid_ff || !rsp_stall);

   // ---------------------------------------------------------------------------
   // Sequencer. RUN takes items, PROJ folds a finished row into the window sums
   // and FIN waits for the scaling unit and a free output register.
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      row_sums_in = row_sums_ff;
      win_in      = win_ff;
      step_in     = step_ff;
      win_end_in  = win_end_ff;
      fin_start   = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (is_pixel) begin
               row_sums_in = row_mac;
               if (col_last) begin
                  col_in     = '0;
                  win_end_in = row_last;
                  row_in     = row_last ? '0 : row_ff + CNT_BITS'(1);
                  step_in    = J_CONST;
                  state_in   = ST_PROJ;
               end else begin
                  col_in = col_ff + CNT_BITS'(1);
               end
            end
         end
         ST_PROJ: begin
            win_in[step_ff] = win_ff[step_ff] + proj_ext[WIN_BITS-1:0];
            if (step_ff == J_DYY) begin
               row_sums_in = '0;
               if (win_end_ff) begin
                  fin_start = 1'b1;
                  state_in  = ST_FIN;
               end else begin
                  state_in = ST_RUN;
               end
            end else begin
               step_in = step_ff + JET_INDEX_BITS'(1);
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               win_in   = '0;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         col_ff      <= '0;
         row_ff      <= '0;
         row_sums_ff <= '0;
         win_ff      <= '0;
         step_ff     <= J_CONST;
         win_end_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         row_sums_ff <= row_sums_in;
         win_ff      <= win_in;
         step_ff     <= step_in;
         win_end_ff  <= win_end_in;
      end
   end

   // The row's own coefficients are captured with its last pixel.
   always_ff @(posedge clock) begin
      if (is_pixel && col_last) begin
         coef_row_ff <= tab_b;
      end
   end

   // ---------------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         cfg_ff         <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_SIZE:      window_size_ff <= csr_wdata[SIZE_BITS-1:0];
            CSR_SCALE_CONST:      cfg_ff.scale_const <= csr_wdata;
            CSR_SCALE_LINEAR:     cfg_ff.scale_linear <= csr_wdata;
            CSR_SCALE_CROSS:      cfg_ff.scale_cross <= csr_wdata;
            CSR_SCALE_SQUARE:     cfg_ff.scale_square <= csr_wdata;
            CSR_CONST_CORRECTION: cfg_ff.const_correction <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Scaling unit and output register.
   // ---------------------------------------------------------------------------
   wqjf_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .start    (fin_start),
      .win_sums (win_ff),
      .cfg      (cfg_ff),
      .busy     (fin_busy),
      .jets     (fin_jets)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_jets_ff <= fin_jets;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_jet_const = $signed(rsp_jets_ff[J_CONST]);
   assign rsp_jet_dx    = $signed(rsp_jets_ff[J_DX]);
   assign rsp_jet_dy    = $signed(rsp_jets_ff[J_DY]);
   assign rsp_jet_dxx   = $signed(rsp_jets_ff[J_DXX]);
   assign rsp_jet_dxy   = $signed(rsp_jets_ff[J_DXY]);
   assign rsp_jet_dyy   = $signed(rsp_jets_ff[J_DYY]);

endmodule

### rtl/core/wqjf_checker.sv
// Port checker for the jet fit block and its bind to the top level.
`include "window_quadratic_jet_fit_2d_macros.svh"

module wqjf_checker import wqjf_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_opcode,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [JET_BITS-1:0] rsp_jet_const,
   input logic [JET_BITS-1:0] rsp_jet_dx,
   input logic [JET_BITS-1:0] rsp_jet_dy,
   input logic [JET_BITS-1:0] rsp_jet_dxx,
   input logic [JET_BITS-1:0] rsp_jet_dxy,
   input logic [JET_BITS-1:0] rsp_jet_dyy
);

   logic [NUM_JETS*JET_BITS-1:0] rsp_word;
   logic                         load_taken;

   assign rsp_word   = {rsp_jet_const, rsp_jet_dx, rsp_jet_dy,
                        rsp_jet_dxx, rsp_jet_dxy, rsp_jet_dyy};
   assign load_taken = req_valid && !req_stall && (req_opcode == OP_LOAD);

   // A stalled result word stays offered and unchanged.
   `WQJF_ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && rsp_stall, rsp_valid, "result word dropped")
   `WQJF_ASSERT_NEXT(a_rsp_word_holds, rsp_valid && rsp_stall, $stable(rsp_word), "result changed")

   // A coefficient load never starts any multi-cycle work.
   `WQJF_ASSERT_NEXT(a_load_no_stall, load_taken, !req_stall, "load stalled the request channel")

   // A result is only produced while the block is busy finishing a window.
   `WQJF_ASSERT(a_rsp_from_finish, $rose(rsp_valid) |-> $past(req_stall), "result outside finish")

endmodule

bind window_quadratic_jet_fit_2d wqjf_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_opcode    (req_opcode),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_jet_const (rsp_jet_const),
   .rsp_jet_dx    (rsp_jet_dx),
   .rsp_jet_dy    (rsp_jet_dy),
   .rsp_jet_dxx   (rsp_jet_dxx),
   .rsp_jet_dxy   (rsp_jet_dxy),
   .rsp_jet_dyy   (rsp_jet_dyy)
);

### dv/tb_window_quadratic_jet_fit_2d.sv
// Self-checking testbench for the weighted quadratic jet fit block, with its own fit predictor.
module tb_window_quadratic_jet_fit_2d;
   import wqjf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WINDOW = 16;
   localparam int COEF_BITS  = 18;
   localparam int PIXEL_BITS = 8;

   // Items in the random part, the pause that covers a row projection plus the
   // scaling unit, the receiver hold and a watchdog far beyond the slowest legal run.
   localparam int RANDOM_ITEMS  = 1100;
   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int TIMEOUT_NS    = 5_000_000;

   // Positions of the three row sums.
   localparam int ROW_CONST = 0;
   localparam int ROW_LIN   = 1;
   localparam int ROW_QUAD  = 2;

   localparam logic [COEF_BITS-1:0]  COEF_MAX  = 18'h1ffff;
   localparam logic [COEF_BITS-1:0]  COEF_MIN  = 18'h20000;
   localparam logic [SCALE_BITS-1:0] SCALE_MAX = 24'h7fffff;
   localparam logic [SCALE_BITS-1:0] SCALE_MIN = 24'h800000;
   localparam logic [SCALE_BITS-1:0] SCALE_ONE = 24'h010000;

   localparam logic signed [79:0] JET_HI = 80'sd2147483647;
   localparam logic signed [79:0] JET_LO = -80'sd2147483648;

   // One request word as the sender sees it.
   typedef struct {
      opcode_type             opcode;
      logic [INDEX_BITS-1:0]  coef_index;
      logic [COEF_BITS-1:0]   coef_const;
      logic [COEF_BITS-1:0]   coef_lin;
      logic [COEF_BITS-1:0]   coef_quad;
      logic [PIXEL_BITS-1:0]  pixel;
   } fit_request_type;

   // One response word: the six jet coefficients.
   typedef struct {
      logic signed [JET_BITS-1:0] jet_const;
      logic signed [JET_BITS-1:0] jet_dx;
      logic signed [JET_BITS-1:0] jet_dy;
      logic signed [JET_BITS-1:0] jet_dxx;
      logic signed [JET_BITS-1:0] jet_dxy;
      logic signed [JET_BITS-1:0] jet_dyy;
   } jet_word_type;

   // Every input of the block starts at a known value.
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_opcode = 1'b0;
   logic [INDEX_BITS-1:0]       req_coef_index = '0;
   logic signed [COEF_BITS-1:0] req_coef_const = '0;
   logic signed [COEF_BITS-1:0] req_coef_lin = '0;
   logic signed [COEF_BITS-1:0] req_coef_quad = '0;
   logic [PIXEL_BITS-1:0]       req_pixel = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [JET_BITS-1:0]  rsp_jet_const;
   logic signed [JET_BITS-1:0]  rsp_jet_dx;
   logic signed [JET_BITS-1:0]  rsp_jet_dy;
   logic signed [JET_BITS-1:0]  rsp_jet_dxx;
   logic signed [JET_BITS-1:0]  rsp_jet_dxy;
   logic signed [JET_BITS-1:0]  rsp_jet_dyy;
   logic                        csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [SCALE_BITS-1:0]       csr_wdata = '0;

   // Shadow copy of the configuration, as the block should hold it.
   logic [SIZE_BITS-1:0]         win_size_r = WINDOW_SIZE_RESET;
   logic signed [SCALE_BITS-1:0] scale_const_r = '0;
   logic signed [SCALE_BITS-1:0] scale_linear_r = '0;
   logic signed [SCALE_BITS-1:0] scale_cross_r = '0;
   logic signed [SCALE_BITS-1:0] scale_square_r = '0;
   logic signed [SCALE_BITS-1:0] corr_r = '0;

   // Fit state of the predictor. Table entries start at zero here, but the
   // stimulus never reads one that it has not loaded.
   logic signed [COEF_BITS-1:0] tab_const [MAX_WINDOW] = '{default: '0};
   logic signed [COEF_BITS-1:0] tab_lin   [MAX_WINDOW] = '{default: '0};
   logic signed [COEF_BITS-1:0] tab_quad  [MAX_WINDOW] = '{default: '0};
   int                          col_cnt = 0;
   int                          row_cnt = 0;
   logic [ROW_BITS-1:0]         row_acc [3] = '{default: '0};
   logic [WIN_BITS-1:0]         win_acc [NUM_JETS] = '{default: '0};

   // Jet words that the block owes, oldest first.
   jet_word_type jets_expected [$];

   int fail_count = 0;

   // When quiet is set neither side idles. A hold is asked for by raising
   // hold_request; the response process counts it out by itself.
   bit quiet = 1'b0;
   int hold_request = 0;
   int hold_taken = 0;
   int hold_left = 0;

   window_quadratic_jet_fit_2d #(
      .MAX_WINDOW (MAX_WINDOW),
      .COEF_BITS  (COEF_BITS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_coef_index (req_coef_index),
      .req_coef_const (req_coef_const),
      .req_coef_lin   (req_coef_lin),
      .req_coef_quad  (req_coef_quad),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_jet_const  (rsp_jet_const),
      .rsp_jet_dx     (rsp_jet_dx),
      .rsp_jet_dy     (rsp_jet_dy),
      .rsp_jet_dxx    (rsp_jet_dxx),
      .rsp_jet_dxy    (rsp_jet_dxy),
      .rsp_jet_dyy    (rsp_jet_dyy),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // The side length the block works with: sizes below two act as two and
   // sizes above the table depth act as the table depth.
   function automatic int eff_size();
      int n;
      n = int'(win_size_r);
      if (n < 2) n = 2;
      if (n > MAX_WINDOW) n = MAX_WINDOW;
      return n;
   endfunction

   // Window sum times a Q7.16 scale, brought back to Q.16 with ties rounded up.
   function automatic logic signed [79:0] scale_round(input logic signed [WIN_BITS-1:0] wsum,
                                                      input logic signed [SCALE_BITS-1:0] sc);
      logic signed [79:0] p;
      p = 80'(wsum);
      p = p * 80'(sc);
      p = p + 80'sd536870912;
      return p >>> 30;
   endfunction

   function automatic logic signed [JET_BITS-1:0] clamp_jet(input logic signed [79:0] v);
      if (v > JET_HI) return 32'sh7fffffff;
      if (v < JET_LO) return 32'sh80000000;
      return v[JET_BITS-1:0];
   endfunction

   // Advance the fit state by one accepted word. A load writes the three
   // tables; a pixel accumulates into the row sums, a row end projects the row
   // sums into the window sums, and a window end queues the jet word it owes.
   // Counters are compared with "at least", so after a shrink a row whose column is
   // at or past the new end closes on its next pixel, and the window too if its row is.
   function automatic void fit_accumulate(input fit_request_type w);
      int n, c, r, k;
      logic signed [ROW_BITS-1:0] s0, s1, s2;
      logic signed [WIN_BITS-1:0] ws [NUM_JETS];
      logic signed [79:0] raw_const, corr;
      jet_word_type jw;
      if (w.opcode == OP_LOAD) begin
         tab_const[w.coef_index] = w.coef_const;
         tab_lin[w.coef_index] = w.coef_lin;
         tab_quad[w.coef_index] = w.coef_quad;
         return;
      end
      n = eff_size();
      c = col_cnt % MAX_WINDOW;
      row_acc[ROW_CONST] = ROW_BITS'(row_acc[ROW_CONST]
                                     + longint'(tab_const[c]) * longint'(w.pixel));
      row_acc[ROW_LIN] = ROW_BITS'(row_acc[ROW_LIN]
                                   + longint'(tab_lin[c]) * longint'(w.pixel));
      row_acc[ROW_QUAD] = ROW_BITS'(row_acc[ROW_QUAD]
                                    + longint'(tab_quad[c]) * longint'(w.pixel));
      if (col_cnt + 1 < n) begin
         col_cnt++;
         return;
      end
      col_cnt = 0;
      r = row_cnt % MAX_WINDOW;
      s0 = row_acc[ROW_CONST];
      s1 = row_acc[ROW_LIN];
      s2 = row_acc[ROW_QUAD];
      win_acc[J_CONST] = WIN_BITS'(win_acc[J_CONST] + longint'(tab_const[r]) * longint'(s0));
      win_acc[J_DX] = WIN_BITS'(win_acc[J_DX] + longint'(tab_const[r]) * longint'(s1));
      win_acc[J_DY] = WIN_BITS'(win_acc[J_DY] + longint'(tab_lin[r]) * longint'(s0));
      win_acc[J_DXX] = WIN_BITS'(win_acc[J_DXX] + longint'(tab_const[r]) * longint'(s2));
      win_acc[J_DXY] = WIN_BITS'(win_acc[J_DXY] + longint'(tab_lin[r]) * longint'(s1));
      win_acc[J_DYY] = WIN_BITS'(win_acc[J_DYY] + longint'(tab_quad[r]) * longint'(s0));
      row_acc = '{default: '0};
      if (row_cnt + 1 < n) begin
         row_cnt++;
         return;
      end
      row_cnt = 0;
      for (k = 0; k < NUM_JETS; k++) ws[k] = win_acc[k];
      raw_const = scale_round(ws[J_CONST], scale_const_r);
      jw.jet_dx = clamp_jet(scale_round(ws[J_DX], scale_linear_r));
      jw.jet_dy = clamp_jet(scale_round(ws[J_DY], scale_linear_r));
      jw.jet_dxx = clamp_jet(scale_round(ws[J_DXX], scale_square_r));
      jw.jet_dxy = clamp_jet(scale_round(ws[J_DXY], scale_cross_r));
      jw.jet_dyy = clamp_jet(scale_round(ws[J_DYY], scale_square_r));
      // The correction works on the saturated squared terms but is taken
      // from the constant term before that one saturates.
      corr = 80'(jw.jet_dxx);
      corr = corr + 80'(jw.jet_dyy);
      corr = corr * 80'(corr_r);
      corr = corr + 80'sd32768;
      corr = corr >>> 16;
      jw.jet_const = clamp_jet(raw_const - corr);
      jets_expected.push_back(jw);
      win_acc = '{default: '0};
   endfunction

   function automatic void check_jet(input string name, input logic signed [JET_BITS-1:0] want,
                                     input logic signed [JET_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Coefficients: a mix of full-range values, small values and the two extremes.
   function automatic logic [COEF_BITS-1:0] rand_coef();
      case ($urandom_range(3))
         0: return COEF_BITS'(int'($urandom_range(4095)) - 2048);
         1: return $urandom_range(1) ? COEF_MAX : COEF_MIN;
         default: return COEF_BITS'($urandom);
      endcase
   endfunction

   // Scales: small, extreme, zero or unity, and full range. Large scales with
   // large coefficients drive the jets into saturation.
   function automatic logic [SCALE_BITS-1:0] rand_scale();
      case ($urandom_range(4))
         0: return SCALE_BITS'(int'($urandom_range(8191)) - 4096);
         1: return $urandom_range(1) ? SCALE_MAX : SCALE_MIN;
         2: return $urandom_range(1) ? SCALE_ONE : '0;
         default: return SCALE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [PIXEL_BITS-1:0] rand_pixel();
      if ($urandom_range(4) == 0) return $urandom_range(1) ? 8'hff : 8'h00;
      return PIXEL_BITS'($urandom);
   endfunction

   function automatic fit_request_type make_load(input int idx, input logic [COEF_BITS-1:0] c,
                                                 input logic [COEF_BITS-1:0] l,
                                                 input logic [COEF_BITS-1:0] q);
      fit_request_type w;
      w.opcode = OP_LOAD;
      w.coef_index = INDEX_BITS'(idx);
      w.coef_const = c;
      w.coef_lin = l;
      w.coef_quad = q;
      w.pixel = PIXEL_BITS'($urandom);
      return w;
   endfunction

   // The coefficient fields of a pixel word carry noise; the block must ignore them.
   function automatic fit_request_type make_pixel(input logic [PIXEL_BITS-1:0] px);
      fit_request_type w;
      w.opcode = OP_PIXEL;
      w.coef_index = INDEX_BITS'($urandom);
      w.coef_const = COEF_BITS'($urandom);
      w.coef_lin = COEF_BITS'($urandom);
      w.coef_quad = COEF_BITS'($urandom);
      w.pixel = px;
      return w;
   endfunction

   // Offer one word and hold it until the block takes it. The valid stays high
   // afterwards, so words can follow back to back; whoever stops sending lowers it.
   // Unless quiet is set, an idle gap is taken now and then before the word.
   task automatic send_word(input fit_request_type w);
      if (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= w.opcode;
      req_coef_index <= w.coef_index;
      req_coef_const <= w.coef_const;
      req_coef_lin <= w.coef_lin;
      req_coef_quad <= w.coef_quad;
      req_pixel <= w.pixel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fit_accumulate(w);
   endtask

   // A run of random pixels, with a load to a random table slot slipped in
   // before a pixel at the given rate.
   task automatic send_pixels(input int count, input int load_pct, inout int sent);
      int i;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(99) < load_pct) begin
            send_word(make_load($urandom_range(MAX_WINDOW - 1), rand_coef(), rand_coef(),
                                rand_coef()));
            sent++;
         end
         send_word(make_pixel(rand_pixel()));
         sent++;
      end
   endtask

   // Stop sending, wait until every owed jet word has come, then give the block
   // time to finish a row projection that produces no word.
   task automatic settle();
      req_valid <= 1'b0;
      while (jets_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write. The enable is left high so that writes can follow
   // each other; program_csrs lowers it.
   task automatic csr_write(input csr_index_type idx, input logic [SCALE_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_WINDOW_SIZE:      win_size_r = val[SIZE_BITS-1:0];
         CSR_SCALE_CONST:      scale_const_r = val;
         CSR_SCALE_LINEAR:     scale_linear_r = val;
         CSR_SCALE_CROSS:      scale_cross_r = val;
         CSR_SCALE_SQUARE:     scale_square_r = val;
         CSR_CONST_CORRECTION: corr_r = val;
         default: ;
      endcase
   endtask

   // Write every register once the block is idle. A window may still be open;
   // its counters carry over into the new size.
   task automatic program_csrs(input logic [SCALE_BITS-1:0] size_w,
                               input logic [SCALE_BITS-1:0] sc, input logic [SCALE_BITS-1:0] sl,
                               input logic [SCALE_BITS-1:0] sx, input logic [SCALE_BITS-1:0] sq,
                               input logic [SCALE_BITS-1:0] cc);
      settle();
      csr_write(CSR_WINDOW_SIZE, size_w);
      csr_write(CSR_SCALE_CONST, sc);
      csr_write(CSR_SCALE_LINEAR, sl);
      csr_write(CSR_SCALE_CROSS, sx);
      csr_write(CSR_SCALE_SQUARE, sq);
      csr_write(CSR_CONST_CORRECTION, cc);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Load slots 0 to 3 for the directed windows: extremes in 0 and 1, random values in 3.
   task automatic test_load_extremes();
      send_word(make_load(0, COEF_MAX, COEF_MIN, COEF_MAX));
      send_word(make_load(1, COEF_MIN, COEF_MAX, COEF_MIN));
      send_word(make_load(2, 18'h00001, 18'h3ffff, 18'h00000));
      send_word(make_load(3, rand_coef(), rand_coef(), rand_coef()));
   endtask

   // One 3 by 3 window under the reset configuration: all scales are zero.
   task automatic test_reset_window();
      int i;
      for (i = 0; i < 9; i++) send_word(make_pixel((i % 2 == 0) ? 8'hff : 8'h00));
   endtask

   // Window sizes zero and one act as two. The first size write carries junk in the
   // bits above the five that count. Extreme scales saturate the jets.
   task automatic test_size_clamp();
      int i;
      program_csrs(24'hffffe0, SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MAX, SCALE_MIN);
      for (i = 0; i < 4; i++) send_word(make_pixel(8'hff));
      program_csrs(24'h000001, SCALE_MIN, SCALE_MIN, SCALE_MIN, SCALE_MIN, SCALE_MAX);
      send_word(make_pixel(8'hff));
      send_word(make_pixel(8'h00));
      send_word(make_pixel(8'h00));
      send_word(make_pixel(8'hff));
   endtask

   // Shrink the window from four to two while the second row is half done:
   // the column counter is already past the new end, so the next pixel closes
   // both the row and the window.
   task automatic test_resize_mid_window();
      int sent;
      sent = 0;
      program_csrs(24'd4, SCALE_ONE, 24'h008000, 24'hff0000, 24'h004000, 24'h000800);
      send_pixels(6, 0, sent);
      program_csrs(24'd2, SCALE_ONE, 24'h008000, 24'hff0000, 24'h004000, 24'h000800);
      send_pixels(1, 0, sent);
   endtask

   // A load in the middle of a window changes the table for the rows still to come.
   task automatic test_load_mid_window();
      int sent;
      sent = 0;
      send_pixels(2, 0, sent);
      send_word(make_load(1, rand_coef(), rand_coef(), rand_coef()));
      send_pixels(2, 0, sent);
   endtask

   // Phases of random configuration, each a few windows of random content with
   // loads mixed in. Now and then a window is cut short, so the next phase
   // resizes a window that is still open.
   task automatic test_random_traffic();
      int sent, i, n, windows, count, pick;
      logic [SIZE_BITS-1:0] sz;
      logic [SCALE_BITS-1:0] size_w;
      sent = 0;
      for (i = 0; i < MAX_WINDOW; i++) begin
         send_word(make_load(i, rand_coef(), rand_coef(), rand_coef()));
         sent++;
      end
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 65) sz = SIZE_BITS'($urandom_range(2, 4));
         else if (pick < 80) sz = SIZE_BITS'($urandom_range(5, 8));
         else if (pick < 88) sz = SIZE_BITS'($urandom_range(9, 15));
         else if (pick < 94) sz = SIZE_BITS'(MAX_WINDOW);
         else if (pick < 97) sz = SIZE_BITS'($urandom_range(0, 1));
         else sz = SIZE_BITS'($urandom_range(MAX_WINDOW + 1, 31));
         size_w = {($urandom_range(3) == 0) ? 19'($urandom) : 19'd0, sz};
         program_csrs(size_w, rand_scale(), rand_scale(), rand_scale(), rand_scale(),
                      rand_scale());
         n = eff_size();
         windows = (n > 8) ? 1 : $urandom_range(2, 6);
         for (i = 0; i < windows; i++) begin
            repeat ($urandom_range(0, 2)) begin
               send_word(make_load($urandom_range(MAX_WINDOW - 1), rand_coef(), rand_coef(),
                                   rand_coef()));
               sent++;
            end
            count = n * n;
            if ($urandom_range(9) == 0) count = $urandom_range(1, n * n - 1);
            send_pixels(count, 5, sent);
         end
      end
   endtask

   // A long stretch with neither side idling.
   task automatic test_streaming();
      int sent;
      sent = 0;
      program_csrs(24'd3, rand_scale(), rand_scale(), rand_scale(), rand_scale(), rand_scale());
      quiet = 1'b1;
      send_pixels(90, 0, sent);
      quiet = 1'b0;
   endtask

   // The receiver holds off for a long stretch while small windows keep coming,
   // so the output register fills and the block has to stall its input. The
   // settle that follows is the pause in which the sender waits for every word.
   task automatic test_backpressure();
      int sent;
      sent = 0;
      program_csrs(24'd2, rand_scale(), rand_scale(), rand_scale(), rand_scale(), rand_scale());
      quiet = 1'b1;
      hold_request++;
      send_pixels(32, 0, sent);
      quiet = 1'b0;
      settle();
   endtask

   // Response side: check each accepted word against the oldest owed word,
   // then decide the stall for the next cycle.
   always @(posedge clock) begin : rsp_side
      jet_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (jets_expected.size() == 0) begin
            $error("jet word arrived with none owed (jet_const %0d)", rsp_jet_const);
            fail_count++;
         end else begin
            want = jets_expected.pop_front();
            check_jet("jet_const", want.jet_const, rsp_jet_const);
            check_jet("jet_dx", want.jet_dx, rsp_jet_dx);
            check_jet("jet_dy", want.jet_dy, rsp_jet_dy);
            check_jet("jet_dxx", want.jet_dxx, rsp_jet_dxx);
            check_jet("jet_dxy", want.jet_dxy, rsp_jet_dxy);
            check_jet("jet_dyy", want.jet_dyy, rsp_jet_dyy);
         end
      end
      if (hold_request != hold_taken) begin
         hold_taken = hold_request;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 8);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_load_extremes();
      test_reset_window();
      test_size_clamp();
      test_resize_mid_window();
      test_load_mid_window();
      test_random_traffic();
      test_streaming();
      test_backpressure();
      settle();
      if (fail_count == 0 && jets_expected.size() == 0) begin
         $display("tb_window_quadratic_jet_fit_2d OK");
      end else begin
         $display("tb_window_quadratic_jet_fit_2d NOT OK");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("tb_window_quadratic_jet_fit_2d NOT OK");
      $finish;
   end

endmodule
